### hw/rtl/oledfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package oledfb_pkg;

  // frame store geometry
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = 12;
  localparam int DATA_W      = 8;

  // default panel size
  localparam int DEF_PANEL_WIDTH  = 128;
  localparam int DEF_PANEL_HEIGHT = 64;

  // operation codes carried on tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // pixel format register codes
  localparam logic FMT_MONO = 1'b0;
  localparam logic FMT_GRAY = 1'b1;

  // luma: sum of weighted 8-bit channels, then divided by 1600 (100 then 16)
  localparam int LUMA_SUM_W = 15;
  localparam int LUMA_RECIP_W = 14;
  localparam logic [LUMA_RECIP_W-1:0] LUMA_RECIP = 14'd10486;  // ceil(2^24 / 1600)
  localparam int LUMA_SHIFT = 24;
  localparam int LUMA_PROD_W = LUMA_SUM_W + LUMA_RECIP_W;

  typedef logic [31:0][12:0] lut_r_t;
  typedef logic [63:0][13:0] lut_g_t;
  typedef logic [31:0][11:0] lut_b_t;

  // 30 * (r * 255 / 31)
  function automatic lut_r_t build_r_lut();
    lut_r_t lut;
    lut = '0;
    for (int i = 0; i < 32; i++) begin
      lut[i] = 13'(30 * ((i * 255) / 31));
    end
    return lut;
  endfunction

  // 59 * (g * 255 / 63)
  function automatic lut_g_t build_g_lut();
    lut_g_t lut;
    lut = '0;
    for (int i = 0; i < 64; i++) begin
      lut[i] = 14'(59 * ((i * 255) / 63));
    end
    return lut;
  endfunction

  // 11 * (b * 255 / 31)
  function automatic lut_b_t build_b_lut();
    lut_b_t lut;
    lut = '0;
    for (int i = 0; i < 32; i++) begin
      lut[i] = 12'(11 * ((i * 255) / 31));
    end
    return lut;
  endfunction

  localparam lut_r_t LUMA_R_LUT = build_r_lut();
  localparam lut_g_t LUMA_G_LUT = build_g_lut();
  localparam lut_b_t LUMA_B_LUT = build_b_lut();

endpackage

`default_nettype wire

### hw/rtl/oledfb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module oledfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hw/rtl/oled_framebuffer_pixel_writer.sv
`timescale 1ns / 1ps
`default_nettype none

// pixel writer for an oled frame store (mono page layout or 4-bit gray)
//
// in_*  : one transaction per operation. in_tuser is the operation (write pixel
//         or read one store byte), in_tdata carries coordinates, colour and the
//         read address. writes produce nothing on the output side.
// out_* : one transaction per read, carrying the byte and the echoed address.
// cfg_* : pixel format register; user writes it only while idle, the block does not check.
//
// every operation has an accept cycle that issues the frame store read, and
// the next cycle merges the pixel into the byte and writes it back (or loads
// the output register for a read), following the store's registered read.
// a new operation is taken only once the last one is through and the block is
// back in idle. out_tvalid rises at the edge after a read's acceptance.
//
// after reset the block walks the whole store writing zeros, one byte a cycle,
// over all 4096 bytes with in_tready low; cfg writes are taken during this pass.
// a stalled output holds its result; in_tready stays low while the output
// register is full and not being taken.
module oled_framebuffer_pixel_writer
  import oledfb_pkg::*;
#(
  parameter int PANEL_WIDTH  = oledfb_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = oledfb_pkg::DEF_PANEL_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // pixel_x[15:0], pixel_y[31:16], color[47:32],
                                       // byte_addr[59:48], zero pad [63:60]
  input  wire logic        in_tuser,   // op: 0 write pixel, 1 read byte
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // read_data[7:0], read_addr[19:8], zero pad [23:20]
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data  // pixel_format
);

  // coordinate and index widths follow the panel size
  localparam int XW = $clog2(PANEL_WIDTH);
  localparam int YW = $clog2(PANEL_HEIGHT);
  localparam int PW = XW + YW;
  localparam int IW = (PW > ADDR_W + 1) ? PW : ADDR_W + 1;

  typedef enum logic [1:0] {
    ST_CLEAR,   // zeroing pass after reset
    ST_IDLE,    // waiting for a transaction
    ST_MODIFY,  // merge pixel into fetched byte and write back
    ST_FETCH    // fetched byte goes to the output register
  } state_t;

  state_t              state_r;
  logic [ADDR_W-1:0]   clr_cnt_r;
  logic                fmt_r;

  // per-operation registers
  logic [ADDR_W-1:0]   addr_r;
  logic                wr_ok_r;
  logic [2:0]          bit_sel_r;
  logic                nib_odd_r;
  logic                color_nz_r;
  logic [LUMA_SUM_W-1:0] luma_sum_r;

  // output register
  logic                out_tvalid_r;
  logic [DATA_W-1:0]   out_data_r;
  logic [ADDR_W-1:0]   out_addr_r;

  // input field unpacking
  logic [15:0]         pix_x;
  logic [15:0]         pix_y;
  logic [15:0]         color;
  logic [ADDR_W-1:0]   rd_byte_addr;

  assign pix_x        = in_tdata[15:0];
  assign pix_y        = in_tdata[31:16];
  assign color        = in_tdata[47:32];
  assign rd_byte_addr = in_tdata[59:48];

  // clipping and byte address
  logic                x_ok;
  logic                y_ok;
  logic [XW-1:0]       xs;
  logic [YW-1:0]       ys;
  logic [IW-1:0]       pix_idx;
  logic [IW-1:0]       page_idx;
  logic [IW-1:0]       byte_idx;
  logic                in_store;
  logic                accept;

  assign x_ok = !pix_x[15] && (pix_x < 16'(PANEL_WIDTH));
  assign y_ok = !pix_y[15] && (pix_y < 16'(PANEL_HEIGHT));
  assign xs   = pix_x[XW-1:0];
  assign ys   = pix_y[YW-1:0];

  // gray: pixel index y*w + x, two pixels per byte
  assign pix_idx  = IW'(ys) * IW'(PANEL_WIDTH) + IW'(xs);
  // mono: page layout, eight rows per byte
  assign page_idx = IW'(ys >> 3) * IW'(PANEL_WIDTH) + IW'(xs);
  assign byte_idx = (fmt_r == FMT_GRAY) ? (pix_idx >> 1) : page_idx;
  assign in_store = byte_idx < IW'(STORE_DEPTH);

  assign in_tready = (state_r == ST_IDLE) && (!out_tvalid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // weighted channel sum, registered before the reciprocal multiply
  logic [LUMA_SUM_W-1:0] luma_sum;

  assign luma_sum = LUMA_SUM_W'(LUMA_R_LUT[color[15:11]])
                  + LUMA_SUM_W'(LUMA_G_LUT[color[10:5]])
                  + LUMA_SUM_W'(LUMA_B_LUT[color[4:0]]);

  // frame store
  logic                ram_wr_en;
  logic [ADDR_W-1:0]   ram_wr_addr;
  logic [DATA_W-1:0]   ram_wr_data;
  logic [ADDR_W-1:0]   ram_rd_addr;
  logic [DATA_W-1:0]   ram_rd_data;

  assign ram_rd_addr = (in_tuser == OP_READ) ? rd_byte_addr : byte_idx[ADDR_W-1:0];

  // gray level: sum / 1600 by reciprocal multiply
  logic [LUMA_PROD_W-1:0] luma_prod;
  logic [3:0]             gray;
  logic [DATA_W-1:0]      bit_mask;
  logic [DATA_W-1:0]      merged;

  assign luma_prod = LUMA_PROD_W'(luma_sum_r) * LUMA_PROD_W'(LUMA_RECIP);
  assign gray      = luma_prod[LUMA_SHIFT +: 4];
  assign bit_mask  = DATA_W'(1) << bit_sel_r;

  always_comb begin
    if (fmt_r == FMT_GRAY) begin
      if (nib_odd_r) begin
        merged = {ram_rd_data[7:4], gray};
      end else begin
        merged = {gray, ram_rd_data[3:0]};
      end
    end else if (color_nz_r) begin
      merged = ram_rd_data | bit_mask;
    end else begin
      merged = ram_rd_data & ~bit_mask;
    end
  end

  assign ram_wr_en   = (state_r == ST_CLEAR) || ((state_r == ST_MODIFY) && wr_ok_r);
  assign ram_wr_addr = (state_r == ST_CLEAR) ? clr_cnt_r : addr_r;
  assign ram_wr_data = (state_r == ST_CLEAR) ? '0 : merged;

  oledfb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      fmt_r        <= FMT_MONO;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fmt_r <= cfg_wr_data;
      end
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == '1) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_r <= (in_tuser == OP_READ) ? ST_FETCH : ST_MODIFY;
          end
        end
        ST_MODIFY: begin
          state_r <= ST_IDLE;
        end
        ST_FETCH: begin
          // output slot is free here, it was free or drained at acceptance
          out_tvalid_r <= 1'b1;
          state_r      <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // payload captured at acceptance, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r     <= ram_rd_addr;
      wr_ok_r    <= x_ok && y_ok && in_store;
      bit_sel_r  <= ys[2:0];
      nib_odd_r  <= pix_idx[0];
      color_nz_r <= (color != '0);
      luma_sum_r <= luma_sum;
    end
    if (state_r == ST_FETCH) begin
      out_data_r <= ram_rd_data;
      out_addr_r <= addr_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0000, out_addr_r, out_data_r};

  // a result only follows an accepted read transaction, through the fetch state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(in_tvalid && in_tready && (in_tuser == OP_READ), 2))
    else $error("result without a preceding read");

  // no write-back may be pending while a new fetch is issued
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !ram_wr_en)
    else $error("store write overlaps a new transaction");

  // the clearing pass covers every entry before the block opens
  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(state_r == ST_CLEAR) |-> ($past(clr_cnt_r) == '1))
    else $error("clearing pass ended early");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import oledfb_pkg::*;

  localparam int PANEL_W     = DEF_PANEL_WIDTH;
  localparam int PANEL_H     = DEF_PANEL_HEIGHT;
  localparam int MONO_BYTES  = PANEL_W * PANEL_H / 8;
  localparam int TIMEOUT_NS  = 3_000_000;
  localparam int SETTLE_CYC  = 4;

  // one expected read transaction
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } read_result_t;

  // shadow copy of the frame store plus the reads still owed by the block
  class frame_store_shadow;
    logic [DATA_W-1:0] store_bytes [STORE_DEPTH];
    logic              fmt;
    read_result_t      pending_reads [$];
    int                errors;

    function new();
      foreach (store_bytes[i]) store_bytes[i] = '0;
      fmt    = FMT_MONO;
      errors = 0;
    endfunction

    function void set_format(logic f);
      fmt = f;
    endfunction

    // rgb565 widened to 8-bit channels, 30/59/11 luma, top nibble kept
    function logic [3:0] gray_level(logic [15:0] colour);
      int unsigned r8, g8, b8, lum;
      r8  = int'(colour[15:11]) * 255 / 31;
      g8  = int'(colour[10:5]) * 255 / 63;
      b8  = int'(colour[4:0]) * 255 / 31;
      lum = (30 * r8 + 59 * g8 + 11 * b8) / 100;
      return 4'(lum >> 4);
    endfunction

    function void note_input(logic op, logic signed [15:0] x, logic signed [15:0] y,
                             logic [15:0] colour, logic [ADDR_W-1:0] addr);
      int           col, row, idx, pix;
      read_result_t owed;
      col = x;
      row = y;
      if (op == OP_READ) begin
        owed.addr = addr;
        owed.data = store_bytes[addr];
        pending_reads.push_back(owed);
        return;
      end
      if (col < 0 || col >= PANEL_W || row < 0 || row >= PANEL_H) return;
      if (fmt == FMT_MONO) begin
        idx = col + (row / 8) * PANEL_W;
        if (idx < STORE_DEPTH) store_bytes[idx][row % 8] = (colour != 0);
      end else begin
        pix = row * PANEL_W + col;
        idx = pix >> 1;
        if (idx < STORE_DEPTH) begin
          if (pix[0]) store_bytes[idx][3:0] = gray_level(colour);
          else store_bytes[idx][7:4] = gray_level(colour);
        end
      end
    endfunction

    function void check_result(logic [23:0] beat);
      read_result_t want;
      if (pending_reads.size() == 0) begin
        errors++;
        $display("%0t: unexpected read result, actual data %h addr %h",
                 $time, beat[7:0], beat[19:8]);
        return;
      end
      want = pending_reads.pop_front();
      if (beat[7:0] !== want.data) begin
        errors++;
        $display("%0t: read_data mismatch at addr %h, expected %h actual %h",
                 $time, want.addr, want.data, beat[7:0]);
      end
      if (beat[19:8] !== want.addr) begin
        errors++;
        $display("%0t: read_addr mismatch, expected %h actual %h",
                 $time, want.addr, beat[19:8]);
      end
    endfunction

    function int owed_count();
      return pending_reads.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;    // pixel_x, pixel_y, colour, byte_addr, zero pad
  logic        in_tuser;    // op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;   // read_data, read_addr, zero pad
  logic        cfg_wr_en;
  logic        cfg_wr_data;

  frame_store_shadow sb = new();

  // idle percentages per cycle for each side, changed between phases
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // current pixel format and the last on-panel pixel written, used to aim reads
  logic cur_format = FMT_MONO;
  int   last_col   = 0;
  int   last_row   = 0;

  always #5 clk = ~clk;

  oled_framebuffer_pixel_writer #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // receiver back-pressure, one decision per cycle at the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // every accepted result transaction is checked against the oldest owed read
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // present one transaction and hold it until the block takes it;
  // returns at a falling edge with tvalid still high so operations can run back to back
  task automatic send_op(logic op, logic signed [15:0] x, logic signed [15:0] y,
                         logic [15:0] colour, logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tuser  = op;
    in_tdata  = {4'b0, addr, colour, y, x};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(op, x, y, colour, addr);
    @(negedge clk);
  endtask

  task automatic write_px(logic signed [15:0] x, logic signed [15:0] y, logic [15:0] colour);
    send_op(OP_WRITE, x, y, colour, 12'($urandom));
  endtask

  task automatic read_byte(logic [ADDR_W-1:0] addr);
    send_op(OP_READ, 16'($urandom), 16'($urandom), 16'($urandom), addr);
  endtask

  // stop sending, wait for every owed read, then let the last write finish
  task automatic settle_block();
    in_tvalid = 1'b0;
    while (sb.owed_count() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_format(logic f);
    settle_block();
    cfg_wr_data = f;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en  = 1'b0;
    cur_format = f;
    sb.set_format(f);
  endtask

  // random mix: mostly on-panel writes, some off-panel noise, reads aimed at
  // recently touched bytes half the time
  task automatic run_random(int count);
    int                  roll;
    logic signed [15:0]  x, y;
    logic [15:0]         colour;
    logic [ADDR_W-1:0]   addr;
    for (int i = 0; i < count; i++) begin
      // hold-off: sender waits until the block has nothing owed
      if (i == count / 2) settle_block();
      roll = $urandom_range(99);
      case ($urandom_range(3))
        0:       colour = 16'h0000;
        1:       colour = 16'hFFFF;
        default: colour = 16'($urandom);
      endcase
      if (roll < 50) begin
        last_col = $urandom_range(PANEL_W - 1);
        last_row = $urandom_range(PANEL_H - 1);
        write_px(16'(last_col), 16'(last_row), colour);
      end else if (roll < 62) begin
        // mostly off the panel, full 16-bit coordinates
        x = 16'($urandom);
        y = 16'($urandom);
        write_px(x, y, colour);
      end else begin
        if ($urandom_range(1)) begin
          if (cur_format == FMT_MONO) addr = 12'(last_col + (last_row / 8) * PANEL_W);
          else addr = 12'((last_row * PANEL_W + last_col) >> 1);
        end else if (cur_format == FMT_MONO) begin
          addr = 12'($urandom_range(MONO_BYTES - 1));
        end else begin
          addr = 12'($urandom);
        end
        read_byte(addr);
      end
    end
  endtask

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_WRITE;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = FMT_MONO;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // the clearing pass runs now; the format register is taken during it
    write_format(FMT_MONO);

    // directed: mono page layout, corners and bit positions
    write_px(16'sd0, 16'sd0, 16'h0001);
    write_px(16'sd127, 16'sd63, 16'hFFFF);
    write_px(16'sd0, 16'sd7, 16'h8000);
    read_byte(12'd0);
    read_byte(12'(MONO_BYTES - 1));
    write_px(16'sd0, 16'sd0, 16'h0000);           // zero colour clears the bit
    read_byte(12'd0);
    // off-panel pixels must leave the store alone
    write_px(-16'sd1, 16'sd0, 16'hFFFF);
    write_px(16'sd128, 16'sd0, 16'hFFFF);
    write_px(16'sd0, -16'sd1, 16'hFFFF);
    write_px(16'sd0, 16'sd64, 16'hFFFF);
    write_px(16'sh8000, 16'sh7FFF, 16'hFFFF);
    write_px(16'sh7FFF, 16'sh8000, 16'hFFFF);
    read_byte(12'd127);
    read_byte(12'hFFF);

    // directed: gray, store kept across the format change
    write_format(FMT_GRAY);
    write_px(16'sd0, 16'sd0, 16'hFFFF);           // even pixel, high nibble
    write_px(16'sd1, 16'sd0, 16'h07E0);           // odd pixel, pure green
    write_px(16'sd127, 16'sd63, 16'hF800);        // last byte, low nibble, red
    write_px(16'sd126, 16'sd63, 16'h001F);        // last byte, high nibble, blue
    read_byte(12'd0);
    read_byte(12'hFFF);
    write_px(16'sd0, 16'sd0, 16'h0000);
    write_px(16'sd5, 16'sd70, 16'hFFFF);
    write_px(-16'sd3, 16'sd5, 16'hFFFF);
    read_byte(12'd0);
    write_format(FMT_MONO);
    read_byte(12'd0);

    // random phases: sender light / receiver heavy, swapped, then no idling
    send_idle_pct = 10;
    recv_idle_pct = 73;
    run_random(400);
    write_format(FMT_GRAY);
    send_idle_pct = 73;
    recv_idle_pct = 10;
    run_random(400);
    write_format(FMT_MONO);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(400);
    write_format(FMT_GRAY);
    run_random(400);

    settle_block();
    repeat (16) @(negedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
